// File: hdl/mmac_pkg.sv
// Package for the matrix multiply-accumulate unit: function codes, widths, saturation helper.
// Used by the cell and the top level.
package mmac_pkg;

    localparam int DefaultDim = 16;
    localparam int IdxW       = 4;
    localparam int AbW        = 16;
    localparam int CW         = 32;
    localparam int FuncW      = 3;

    localparam logic [FuncW-1:0] FUNC_LOAD_A  = 3'd0;
    localparam logic [FuncW-1:0] FUNC_LOAD_B  = 3'd1;
    localparam logic [FuncW-1:0] FUNC_LOAD_C  = 3'd2;
    localparam logic [FuncW-1:0] FUNC_COMPUTE = 3'd3;
    localparam logic [FuncW-1:0] FUNC_READ_C  = 3'd4;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic [FuncW-1:0]     func;
        logic [IdxW-1:0]      row;
        logic [IdxW-1:0]      col;
        logic signed [CW-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic signed [CW-1:0] value;
        logic                 kind;
        logic                 saturated;
    } rsp_t;

    // Adds a product to a Q16.16 sum and clips to the signed 32-bit range.
    function automatic logic [CW:0] sat_add(logic signed [CW-1:0] acc,
                                            logic signed [CW-1:0] prod);
        logic signed [CW:0] s;
        begin
            s = {acc[CW-1], acc} + {prod[CW-1], prod};
            if (s[CW] != s[CW-1])
            begin
                sat_add = {1'b1, s[CW], {(CW-1){~s[CW]}}};
            end
            else
            begin
                sat_add = {1'b0, s[CW-1:0]};
            end
        end
    endfunction

endpackage

// File: hdl/mmac_stream_if.sv
// Valid/ready channel carrying one item of type T.
// Does not import mmac_pkg; the payload type is the parameter T.
interface mmac_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/mmac_cell.sv
// One multiply-accumulate cell of the array: owns one column of the running sums.
// Depends on mmac_pkg for the saturating add.
module mmac_cell
    import mmac_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic                  load,
    input  logic signed [CW-1:0]  c_in,
    input  logic signed [AbW-1:0] a_in,
    input  logic signed [AbW-1:0] b_in,
    output logic signed [CW-1:0]  acc,
    output logic                  clip
);
    logic signed [CW-1:0]  acc_reg;
    logic signed [CW-1:0]  prod;
    logic [CW:0]           sum;

    // Both factors are sign-extended first, so the full Q16.16 product is kept.
    assign prod = CW'(a_in) * CW'(b_in);
    assign sum  = sat_add(acc_reg, prod);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            acc_reg <= c_in;
        end
        else if (en)
        begin
            acc_reg <= sum[CW-1:0];
        end
    end

    assign acc   = acc_reg;
    assign clip  = en & ~load & sum[CW];
endmodule

// File: hdl/matrix_multiply_accumulate_unit.sv
// Top level of the matrix multiply-accumulate unit, C += A*B over DIM x DIM matrices.
// Depends on mmac_pkg, mmac_stream_if and mmac_cell.
//
// Loads take one item per cycle while the unit is idle. A read item is answered from a
// registered store read: its result is registered in rd_c_reg and then loaded into the
// output register, and no item is taken in the cycle right after a read, nor while a
// result waits in the output register with rsp.ready low. A compute item runs row by
// row: for each row i the C row is read from the store and shifts into a register
// chain, and the cells take it once its last element is in. Then for p = 0..DIM-1 row
// B[p][*] is gathered one element per cycle into a shifting row register, and in its
// last cycle every cell j adds A[i][p]*B[p][j] with saturation, in ascending p. The
// finished row is written back to the C store. Stores and data registers are not
// reset; the control registers and the clip flag are.
module matrix_multiply_accumulate_unit
    import mmac_pkg::*;
#(
    parameter int DIM = DefaultDim
)
(
    input  logic                clk,
    input  logic                rst_n,
    mmac_stream_if.sink         cmd,
    mmac_stream_if.source       rsp
);
    localparam int Cells = DIM * DIM;
    localparam int AW    = (Cells > 1) ? $clog2(Cells) : 1;
    localparam int DW    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int CntW  = $clog2(DIM + 1) + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LDC  = 3'd1;
    localparam logic [2:0] ST_MAC  = 3'd2;
    localparam logic [2:0] ST_WB   = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [AbW-1:0] a_mem [Cells];
    logic [AbW-1:0] b_mem [Cells];
    logic [CW-1:0]  c_mem [Cells];

    logic [2:0]      state_reg, state_next;
    logic [DW-1:0]   i_reg, i_next;
    logic [CntW-1:0] k_reg, k_next;
    logic            clip_reg, clip_next;
    logic            ovalid_reg;
    rsp_t            orsp_reg;
    logic            rd_pend_reg;
    logic            rd_ok_reg;
    logic [CW-1:0]   rd_c_reg;
    logic [AbW-1:0]  rd_a_reg;
    logic [AbW-1:0]  b_row_reg [DIM];
    logic [CW-1:0]   c_row_reg [DIM];
    logic            ld_reg, mac_reg;

    logic            in_range, accept, idle;
    logic [AW-1:0]   addr;
    logic signed [CW-1:0]  accs [DIM];
    logic [DIM-1:0]        clips;

    assign in_range = ({28'd0, cmd.payload.row} < 32'(DIM))
                    && ({28'd0, cmd.payload.col} < 32'(DIM));
    assign addr     = AW'(32'(cmd.payload.row) * 32'(DIM) + 32'(cmd.payload.col));
    assign idle     = (state_reg == ST_IDLE) && !rd_pend_reg;
    assign cmd.ready = idle && (!ovalid_reg || rsp.ready);
    assign accept   = cmd.valid && cmd.ready;

    // Stores: single write port, registered reads. Write-back takes each finished
    // sum straight from its cell.
    always_ff @(posedge clk)
    begin
        if (accept && in_range && cmd.payload.func == FUNC_LOAD_A)
        begin
            a_mem[addr] <= cmd.payload.data[AbW-1:0];
        end
        if (accept && in_range && cmd.payload.func == FUNC_LOAD_B)
        begin
            b_mem[addr] <= cmd.payload.data[AbW-1:0];
        end
        if (accept && in_range && cmd.payload.func == FUNC_LOAD_C)
        begin
            c_mem[addr] <= cmd.payload.data;
        end
        else if (state_reg == ST_WB)
        begin
            c_mem[AW'(32'(i_reg) * 32'(DIM) + 32'(k_reg))] <= accs[k_reg[DW-1:0]];
        end
        rd_c_reg <= (state_reg == ST_LDC)
                  ? c_mem[AW'(32'(i_reg) * 32'(DIM) + 32'(k_reg))] : c_mem[addr];
        rd_a_reg <= a_mem[AW'(32'(i_reg) * 32'(DIM) + 32'(k_reg))];
    end

    // B row fetch: during the MAC pass, row k of B is read one element per cycle
    // and shifted into the B row register chain.
    logic [AbW-1:0] b_rd_reg;
    logic [CntW-1:0] bj_reg;
    always_ff @(posedge clk)
    begin
        b_rd_reg <= b_mem[AW'(32'(k_reg) * 32'(DIM) + 32'(bj_reg))];
    end

    // Row registers: the C row shifts in before each MAC pass; the B row shifts in
    // all through the pass.
    always_ff @(posedge clk)
    begin
        if (ld_reg)
        begin
            for (int j = 0; j < DIM - 1; j++)
            begin
                c_row_reg[j] <= c_row_reg[j+1];
            end
            c_row_reg[DIM-1] <= rd_c_reg;
        end
        if (state_reg == ST_MAC)
        begin
            for (int j = 0; j < DIM - 1; j++)
            begin
                b_row_reg[j] <= b_row_reg[j+1];
            end
            b_row_reg[DIM-1] <= b_rd_reg;
        end
    end

    // MAC sequencing inside ST_MAC: bj walks 0..DIM+1 gathering row p of B through b_rd_reg
    // and the row register chain, and its last step is the fire cycle that applies the row to all cells.
    logic fire;
    assign fire = (state_reg == ST_MAC) && (bj_reg == CntW'(DIM + 1));

    generate
        for (genvar j = 0; j < DIM; j++)
        begin : g_cell
            mmac_cell u_cell (
                .clk   (clk),
                .en    (fire),
                .load  (mac_reg),
                .c_in  (c_row_reg[j]),
                .a_in  (rd_a_reg),
                .b_in  (b_row_reg[j]),
                .acc   (accs[j]),
                .clip  (clips[j])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        clip_next  = clip_reg | (|clips);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.payload.func == FUNC_COMPUTE)
                begin
                    state_next = ST_LDC;
                    i_next     = '0;
                    k_next     = '0;
                end
            end
            ST_LDC:
            begin
                if (k_reg == CntW'(DIM - 1))
                begin
                    state_next = ST_MAC;
                    k_next     = '0;
                end
                else
                begin
                    k_next = k_reg + CntW'(1);
                end
            end
            ST_MAC:
            begin
                if (fire)
                begin
                    if (k_reg == CntW'(DIM - 1))
                    begin
                        state_next = ST_WB;
                        k_next     = '0;
                    end
                    else
                    begin
                        k_next = k_reg + CntW'(1);
                    end
                end
            end
            ST_WB:
            begin
                if (k_reg == CntW'(DIM - 1))
                begin
                    k_next = '0;
                    if (32'(i_reg) == DIM - 1)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_LDC;
                        i_next     = i_reg + DW'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + CntW'(1);
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            k_reg       <= '0;
            clip_reg    <= 1'b0;
            ovalid_reg  <= 1'b0;
            rd_pend_reg <= 1'b0;
            rd_ok_reg   <= 1'b0;
            ld_reg      <= 1'b0;
            mac_reg     <= 1'b0;
            bj_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            clip_reg  <= clip_next;
            ld_reg    <= (state_reg == ST_LDC);
            // Cells take the C row once its last element has shifted in.
            mac_reg   <= ld_reg && (state_reg == ST_MAC);
            if (state_reg == ST_MAC && !mac_reg && !ld_reg)
            begin
                bj_reg <= fire ? '0 : bj_reg + CntW'(1);
            end
            else
            begin
                bj_reg <= '0;
            end
            rd_pend_reg <= accept && cmd.payload.func == FUNC_READ_C;
            rd_ok_reg   <= in_range;
            if (rd_pend_reg || (state_reg == ST_DONE && (!ovalid_reg || rsp.ready)))
            begin
                ovalid_reg <= 1'b1;
            end
            else if (rsp.valid && rsp.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg)
        begin
            orsp_reg.value     <= rd_ok_reg ? rd_c_reg : '0;
            orsp_reg.kind      <= KIND_READ;
            orsp_reg.saturated <= clip_reg;
        end
        else if (state_reg == ST_DONE && (!ovalid_reg || rsp.ready))
        begin
            orsp_reg.value     <= '0;
            orsp_reg.kind      <= KIND_DONE;
            orsp_reg.saturated <= clip_reg;
        end
    end

    assign rsp.valid   = ovalid_reg;
    assign rsp.payload = orsp_reg;

    property p_no_accept_busy;
        @(posedge clk) disable iff (!rst_n) (state_reg != ST_IDLE) |-> !cmd.ready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

    property p_clip_sticky;
        @(posedge clk) disable iff (!rst_n) clip_reg |=> clip_reg;
    endproperty
    a_clip_sticky: assert property (p_clip_sticky) else $error("clip flag dropped");

    property p_done_result;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_DONE && state_next == ST_IDLE) |=> rsp.valid;
    endproperty
    a_done_result: assert property (p_done_result) else $error("missing done result");
endmodule
